// ===== sv/sort_points_by_distance_macros.svh =====
// Assertion helpers shared by the sorter RTL.
// Each check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef SORT_POINTS_BY_DISTANCE_MACROS_SVH
`define SORT_POINTS_BY_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spd_pkg.sv =====
package spd_pkg;

    localparam int MAX_POINTS = 16;
    localparam int MAX_DIMS   = 8;

    localparam int COORD_W    = 16;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int KEY_W      = 34;
    localparam int IDX_W      = 4;
    localparam int DIM_W      = 4;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CDIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS + 1) : 1;

    localparam logic [DIM_W-1:0] DIMS_RESET = DIM_W'(5);

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [IDX_W-1:0] t_idx;

    // finished point travelling from the accumulator to the cell chain
    typedef struct packed {
        logic vld;
        t_key key;
        t_idx idx;
    } t_point;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_COLLECT = 3'b001,
        ST_DRAIN   = 3'b010,
        ST_EMIT    = 3'b100
    } t_state;

endpackage

// ===== sv/spd_pts_if.sv =====
interface spd_pts_if import spd_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coordinate;
    logic                      end_of_set;

    modport source (output valid, coordinate, end_of_set, input ready);
    modport sink   (input valid, coordinate, end_of_set, output ready);

endinterface

// ===== sv/spd_res_if.sv =====
interface spd_res_if import spd_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] point_index;
    logic [KEY_W-1:0] distance_squared;
    logic             last_in_order;
    logic             points_dropped;

    modport source (output valid, point_index, distance_squared, last_in_order, points_dropped,
                    input ready);
    modport sink   (input valid, point_index, distance_squared, last_in_order, points_dropped,
                    output ready);

endinterface

// ===== sv/spd_accum.sv =====
// Squares each coordinate, then folds it into the running sum of the point.
module spd_accum import spd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic signed [COORD_W-1:0] i_coordinate,
    input  logic                      i_end_of_set,
    input  logic [DIM_W-1:0]          i_dims,
    input  logic                      i_clear,
    output logic                      o_busy,
    output t_point                    o_pt
);

    logic signed [SQ_W-1:0] w_prod;
    logic [CDIM_W-1:0]      w_eff;
    logic [KEY_W:0]         w_sum_wide;
    t_key                   w_sum;
    logic [CDIM_W:0]        w_cnt_inc;
    logic                   w_done;

    logic                   r_sq_vld;
    logic                   r_sq_end;
    logic [SQ_W-1:0]        r_sq;
    t_key                   r_sum;
    logic [CDIM_W-1:0]      r_cnt;
    t_idx                   r_arr;
    t_point                 r_pt;

    assign w_prod = i_coordinate * i_coordinate;

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (i_dims == '0) begin
            w_eff = CDIM_W'(1);
        end else if (int'(i_dims) > MAX_DIMS) begin
            w_eff = CDIM_W'(MAX_DIMS);
        end else begin
            w_eff = CDIM_W'(i_dims);
        end
    end

    assign w_sum_wide = {1'b0, r_sum} + (KEY_W + 1)'(r_sq);
    assign w_sum      = w_sum_wide[KEY_W] ? '1 : w_sum_wide[KEY_W-1:0];
    assign w_cnt_inc  = {1'b0, r_cnt} + (CDIM_W + 1)'(1);
    // a short final point closes as if zero padded
    assign w_done     = (w_cnt_inc >= {1'b0, w_eff}) || r_sq_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
        end else begin
            r_sq_vld <= i_take;
        end
        if (i_take) begin
            r_sq     <= unsigned'(w_prod);
            r_sq_end <= i_end_of_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_cnt    <= '0;
            r_arr    <= '0;
            r_pt.vld <= 1'b0;
        end else begin
            r_pt.vld <= r_sq_vld && w_done;
            if (r_sq_vld) begin
                if (w_done) begin
                    r_sum    <= '0;
                    r_cnt    <= '0;
                    r_arr    <= r_arr + IDX_W'(1);
                    r_pt.key <= w_sum;
                    r_pt.idx <= r_arr;
                end else begin
                    r_sum <= w_sum;
                    r_cnt <= w_cnt_inc[CDIM_W-1:0];
                end
            end
            if (i_clear) begin
                r_arr <= '0;
            end
        end
    end

    assign o_busy = r_sq_vld;
    assign o_pt   = r_pt;

endmodule

// ===== sv/spd_cell.sv =====
// One slot of the sorted chain. Opens a gap for a smaller key on insert,
// takes its right neighbour's contents on shift-out.
module spd_cell import spd_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_key      i_new_key,
    input  t_idx      i_new_idx,
    input  t_key      i_left_key,
    input  t_idx      i_left_idx,
    input  logic      i_left_shift,
    input  t_key      i_right_key,
    input  t_idx      i_right_idx,
    output t_key      o_key,
    output t_idx      o_idx,
    output logic      o_shift
);

    t_key r_key;
    t_idx r_idx;

    // strict compare keeps equal keys in arrival order
    assign o_shift = i_ctl.insert && (!i_occupied || (r_key > i_new_key));

    always_ff @(posedge i_clk) begin
        if (o_shift) begin
            r_key <= i_left_shift ? i_left_key : i_new_key;
            r_idx <= i_left_shift ? i_left_idx : i_new_idx;
        end else if (i_ctl.shift_out) begin
            r_key <= i_right_key;
            r_idx <= i_right_idx;
        end
    end

    assign o_key = r_key;
    assign o_idx = r_idx;

endmodule

// ===== sv/sort_points_by_distance.sv =====
// The last coordinate is squared into r_sq, the point closed in r_pt, then put in the chain.
// Throughput: one coordinate request per cycle while collecting a set.
// After end_of_set: drain, then one result per cycle unless stalled, one per stored point.
// No request is taken from end_of_set until the last result is loaded into the output stage.
// Reset (synchronous, i_rst_n low): chain empty, sums and counts zero, dimensions = 5.
`include "sort_points_by_distance_macros.svh"

module sort_points_by_distance import spd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data,
    spd_pts_if.sink          i_pts,
    spd_res_if.source        o_res
);

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    t_state           r_state;
    t_state           n_state;
    logic [DIM_W-1:0] r_dims;
    logic [CNT_W-1:0] r_point_count;
    logic             r_ovf;

    // output stage: decouples the chain from a stalled consumer
    logic             r_out_vld;
    t_idx             r_out_idx;
    t_key             r_out_key;
    logic             r_out_last;
    logic             r_out_drop;

    logic             w_take;
    logic             w_busy;
    t_point           w_pt;
    logic             w_room;
    logic             w_load;
    logic             w_final;
    t_cell_ctl        w_ctl;

    t_key             w_key   [MAX_POINTS];
    t_idx             w_idx   [MAX_POINTS];
    logic             w_shift [MAX_POINTS];
    logic             w_occ   [MAX_POINTS];

    // Requests are taken only while collecting; the end_of_set request
    // moves us to the drain state so the pipeline can empty.
    assign i_pts.ready = (r_state == ST_COLLECT);
    assign w_take      = i_pts.valid && i_pts.ready;

    // ---------------------------------------------------------------------
    // Square and accumulate
    // ---------------------------------------------------------------------
    spd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_coordinate (i_pts.coordinate),
        .i_end_of_set (i_pts.end_of_set),
        .i_dims       (r_dims),
        .i_clear      (w_final),
        .o_busy       (w_busy),
        .o_pt         (w_pt)
    );

    // ---------------------------------------------------------------------
    // Sorted chain: ascending keys from cell 0. An incoming point is
    // compared by every cell at once; cells above it move one place right.
    // During emission the chain slides left and cell 0 feeds the output.
    // ---------------------------------------------------------------------
    assign w_room  = (r_point_count < CNT_W'(MAX_POINTS));
    assign w_load  = (r_state == ST_EMIT) && (!r_out_vld || o_res.ready);
    assign w_final = w_load && (r_point_count == CNT_W'(1));
    assign w_ctl   = '{insert: w_pt.vld && w_room, shift_out: w_load};

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_point_count);

        if (g == 0) begin : g_head
            spd_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (w_occ[g]),
                .i_new_key    (w_pt.key),
                .i_new_idx    (w_pt.idx),
                .i_left_key   (w_pt.key),
                .i_left_idx   (w_pt.idx),
                .i_left_shift (1'b0),
                .i_right_key  (w_key[g+1]),
                .i_right_idx  (w_idx[g+1]),
                .o_key        (w_key[g]),
                .o_idx        (w_idx[g]),
                .o_shift      (w_shift[g])
            );
        end else if (g == MAX_POINTS - 1) begin : g_tail
            spd_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (w_occ[g]),
                .i_new_key    (w_pt.key),
                .i_new_idx    (w_pt.idx),
                .i_left_key   (w_key[g-1]),
                .i_left_idx   (w_idx[g-1]),
                .i_left_shift (w_shift[g-1]),
                .i_right_key  (w_pt.key),
                .i_right_idx  (w_pt.idx),
                .o_key        (w_key[g]),
                .o_idx        (w_idx[g]),
                .o_shift      (w_shift[g])
            );
        end else begin : g_mid
            spd_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (w_occ[g]),
                .i_new_key    (w_pt.key),
                .i_new_idx    (w_pt.idx),
                .i_left_key   (w_key[g-1]),
                .i_left_idx   (w_idx[g-1]),
                .i_left_shift (w_shift[g-1]),
                .i_right_key  (w_key[g+1]),
                .i_right_idx  (w_idx[g+1]),
                .o_key        (w_key[g]),
                .o_idx        (w_idx[g]),
                .o_shift      (w_shift[g])
            );
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (w_take && i_pts.end_of_set) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last point has reached the chain
                if (!w_busy && !w_pt.vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_final) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_COLLECT;
            r_dims        <= DIMS_RESET;
            r_point_count <= '0;
            r_ovf         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_dims <= i_cfg_data;
            end
            // stores and emission never overlap
            if (w_pt.vld) begin
                if (w_room) begin
                    r_point_count <= r_point_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (w_load) begin
                r_point_count <= r_point_count - CNT_W'(1);
            end
            if (w_final) begin
                r_ovf <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output stage
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_load) begin
            r_out_idx  <= w_idx[0];
            r_out_key  <= w_key[0];
            r_out_last <= w_final;
            r_out_drop <= w_final && r_ovf;
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.point_index      = r_out_idx;
    assign o_res.distance_squared = r_out_key;
    assign o_res.last_in_order    = r_out_last;
    assign o_res.points_dropped   = r_out_drop;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `SPD_ASSERT_NOW(a_head_sorted, w_load && (r_point_count > CNT_W'(1)), w_key[0] <= w_key[1], "chain head out of order")
    `SPD_ASSERT_NOW(a_count_bound, 1'b1, r_point_count <= CNT_W'(MAX_POINTS), "point count beyond capacity")
    `SPD_ASSERT_NOW(a_emit_nonempty, r_state == ST_EMIT, r_point_count != '0, "emitting from an empty chain")
    `SPD_ASSERT_NEXT(a_final_returns, w_final, (r_state == ST_COLLECT) && (r_point_count == '0) && !r_ovf, "run not cleared after last result")
    `SPD_ASSERT_NOW(a_no_store_in_emit, r_state == ST_EMIT, !w_pt.vld && !w_busy, "point arrived during emission")

endmodule
